// ===== rtl/aad_pkg.sv =====
// Shared types and constants of the area-average downsampler.
`default_nettype none
package aad_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int LEN_BITS    = 13;
   localparam int POS_BITS    = 12;
   localparam int ACC_BITS    = 28;
   localparam int RECIP_BITS  = 33;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [LEN_BITS-1:0] MAX_LEN = 13'd4096;
   localparam logic [LEN_BITS-1:0] MIN_LEN = 13'd1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_IN_LEN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUT_LEN = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECIP   = 2'd2;

   // effective lengths seen by the front end
   typedef struct packed {
      logic [LEN_BITS-1:0] n_in;
      logic [LEN_BITS-1:0] n_out;
      logic                restart;
   } aad_cfg_type;

   // one classified request, front to back
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic [LEN_BITS-1:0]    weight_a;  // overlap with the current output span
      logic [LEN_BITS-1:0]    weight_b;  // overlap carried into the next span
      logic                   emit;
      logic [POS_BITS-1:0]    out_index;
      logic                   last;
   } aad_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/aad_req_if.sv =====
// Request channel: one input sample per transfer.
`default_nettype none
interface aad_req_if;
   import aad_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source  (output valid, output sample, input ready);
   modport sink    (input valid, input sample, output ready);
   modport monitor (input valid, input sample, input ready);
endinterface
`default_nettype wire

// ===== rtl/aad_rsp_if.sv =====
// Result channel: one averaged output pixel per transfer.
`default_nettype none
interface aad_rsp_if;
   import aad_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] out_value;
   logic [POS_BITS-1:0]    out_index;
   logic                   last;

   modport source  (output valid, output out_value, output out_index, output last,
                    input ready);
   modport sink    (input valid, input out_value, input out_index, input last,
                    output ready);
   modport monitor (input valid, input out_value, input out_index, input last,
                    input ready);
endinterface
`default_nettype wire

// ===== rtl/area_average_downsampler.sv =====
// Top level of the area-average downsampler.
// A column of in_len unsigned 16-bit samples arrives on req_chan, one per
// request, and out_len area-averaged pixels leave on rsp_chan, each with its
// index in the column and a last flag on the final one. Input sample k spans
// [k*out_len, (k+1)*out_len) and output j spans [j*in_len, (j+1)*in_len);
// each output is the overlap-weighted sum times recip (round(2^32/in_len)),
// rounded to nearest and saturated to 16 bits. in_len is clamped to
// [1, 4096] and out_len to [1, in_len]. Writing in_len or out_len starts a
// new column; recip may be rewritten freely. Write registers only while the
// block is idle. The front end accepts one request per cycle while its
// four-entry command queue has room. The back-end sequencer steps a sample
// that closes no output through pop, weight multiply and accumulate, and one
// that closes an output also through the scale multiply and the round stage,
// where it waits while the result register still holds an untaken result; it
// pops no new sample until it is through with the last. The result register
// lets the next sample proceed while a result waits. No clearing pass follows reset.
`default_nettype none
module area_average_downsampler
   import aad_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [RECIP_BITS-1:0]   csr_wdata,
   aad_req_if.sink                      req_chan,
   aad_rsp_if.source                    rsp_chan
);
   logic [LEN_BITS-1:0]   in_len_ff, in_len_in;
   logic [LEN_BITS-1:0]   out_len_ff, out_len_in;
   logic [RECIP_BITS-1:0] recip_ff, recip_in;

   aad_cfg_type cfg;
   aad_cmd_type push_cmd;
   aad_cmd_type pop_cmd;
   logic        cfg_restart;
   logic        push;
   logic        pop;
   logic        fifo_full;
   logic        fifo_empty;

   // register writes; a length write abandons the column
   always_comb begin
      in_len_in   = in_len_ff;
      out_len_in  = out_len_ff;
      recip_in    = recip_ff;
      cfg_restart = 1'b0;
      if (csr_we) begin
         case (csr_index)
            CSR_IN_LEN: begin
               in_len_in   = csr_wdata[LEN_BITS-1:0];
               cfg_restart = 1'b1;
            end
            CSR_OUT_LEN: begin
               out_len_in  = csr_wdata[LEN_BITS-1:0];
               cfg_restart = 1'b1;
            end
            CSR_RECIP: begin
               recip_in = csr_wdata;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   // effective lengths
   always_comb begin
      cfg.restart = cfg_restart;
      if (in_len_ff < MIN_LEN) begin
         cfg.n_in = MIN_LEN;
      end else if (in_len_ff > MAX_LEN) begin
         cfg.n_in = MAX_LEN;
      end else begin
         cfg.n_in = in_len_ff;
      end
      if (out_len_ff < MIN_LEN) begin
         cfg.n_out = MIN_LEN;
      end else if (out_len_ff > cfg.n_in) begin
         cfg.n_out = cfg.n_in;
      end else begin
         cfg.n_out = out_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_len_ff  <= MIN_LEN;
         out_len_ff <= MIN_LEN;
         recip_ff   <= {1'b1, {(RECIP_BITS-1){1'b0}}};
      end else begin
         in_len_ff  <= in_len_in;
         out_len_ff <= out_len_in;
         recip_ff   <= recip_in;
      end
   end

   aad_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .cmd       (push_cmd)
   );

   aad_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .full      (fifo_full),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .empty     (fifo_empty)
   );

   aad_back u_back (
      .clock    (clock),
      .reset    (reset),
      .restart  (cfg.restart),
      .recip    (recip_ff),
      .empty    (fifo_empty),
      .pop_data (pop_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule
`default_nettype wire

// ===== rtl/aad_cmd_fifo.sv =====
// Four-entry command queue between front and back end.
`default_nettype none
module aad_cmd_fifo
   import aad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire aad_cmd_type push_data,
   output logic             full,
   input  wire logic        pop,
   output aad_cmd_type      pop_data,
   output logic             empty
);
   localparam int DEPTH = 4;
   localparam int PTR_BITS = $clog2(DEPTH);

   aad_cmd_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == (PTR_BITS+1)'(DEPTH));
   assign empty    = (count_ff == '0);
endmodule
`default_nettype wire

// ===== rtl/aad_front.sv =====
// Front end: takes samples, tracks span boundaries, queues weighted commands.
`default_nettype none
module aad_front
   import aad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire aad_cfg_type cfg,
   aad_req_if.sink          req_chan,
   input  wire logic        fifo_full,
   output logic             push,
   output aad_cmd_type      cmd
);
   logic [LEN_BITS-1:0] bound_ff, bound_in;   // room left in the output span, 0 = fresh
   logic [POS_BITS-1:0] in_pos_ff, in_pos_in;
   logic [POS_BITS-1:0] out_pos_ff, out_pos_in;

   logic [LEN_BITS-1:0] bound_fix;
   logic [LEN_BITS-1:0] rem;
   logic [LEN_BITS-1:0] in_next;
   logic [LEN_BITS-1:0] out_next;
   logic                close;
   logic                col_end;

   assign req_chan.ready = !fifo_full;
   assign push = req_chan.valid && req_chan.ready;

   always_comb begin
      bound_fix = (bound_ff == '0 || bound_ff > cfg.n_in) ? cfg.n_in : bound_ff;
      close     = (cfg.n_out >= bound_fix);
      rem       = cfg.n_out - bound_fix;
      in_next   = {1'b0, in_pos_ff} + 1'b1;
      out_next  = {1'b0, out_pos_ff} + 1'b1;
      col_end   = (in_next >= cfg.n_in);

      cmd.sample    = req_chan.sample;
      cmd.weight_a  = close ? bound_fix : cfg.n_out;
      cmd.weight_b  = (close && !col_end) ? rem : '0;
      cmd.emit      = close;
      cmd.out_index = out_pos_ff;
      cmd.last      = (out_next >= cfg.n_out);

      bound_in   = bound_ff;
      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      if (cfg.restart) begin
         bound_in   = '0;
         in_pos_in  = '0;
         out_pos_in = '0;
      end else if (push) begin
         if (col_end) begin
            bound_in   = '0;
            in_pos_in  = '0;
            out_pos_in = '0;
         end else begin
            in_pos_in = in_next[POS_BITS-1:0];
            if (close) begin
               bound_in   = cfg.n_in - rem;
               out_pos_in = out_next[POS_BITS-1:0];
            end else begin
               bound_in = bound_fix - cfg.n_out;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff   <= '0;
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
      end else begin
         bound_ff   <= bound_in;
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/aad_back.sv =====
// Back end: weights and accumulates samples, scales closed spans, holds the result.
`default_nettype none
module aad_back
   import aad_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  restart,
   input  wire logic [RECIP_BITS-1:0] recip,
   input  wire logic                  empty,
   input  wire aad_cmd_type           pop_data,
   output logic                       pop,
   aad_rsp_if.source                  rsp_chan
);
   localparam int PROD_BITS  = ACC_BITS + RECIP_BITS - 1;   // sum times low recip bits
   localparam int TOTAL_BITS = PROD_BITS + 2;
   localparam int FRAC_BITS  = RECIP_BITS - 1;
   localparam int VAL_BITS   = TOTAL_BITS - FRAC_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;

   logic [2:0]             state_ff, state_in;
   aad_cmd_type            cmd_ff, cmd_in;
   logic [ACC_BITS-1:0]    part_a_ff, part_a_in;
   logic [ACC_BITS-1:0]    part_b_ff, part_b_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [ACC_BITS-1:0]    sum_ff, sum_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] out_value_ff, out_value_in;
   logic [POS_BITS-1:0]    out_index_ff, out_index_in;
   logic                   last_ff, last_in;

   logic [ACC_BITS-1:0]    acc_sum;
   logic [TOTAL_BITS-1:0]  total;
   logic [VAL_BITS-1:0]    scaled;
   logic                   out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop      = (state_ff == ST_IDLE) && !empty;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      part_a_in    = part_a_ff;
      part_b_in    = part_b_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      out_value_in = out_value_ff;
      out_index_in = out_index_ff;
      last_in      = last_ff;

      acc_sum = acc_ff + part_a_ff;
      total   = TOTAL_BITS'(prod_ff)
              + (recip[RECIP_BITS-1] ? (TOTAL_BITS'(sum_ff) << FRAC_BITS) : '0)
              + (TOTAL_BITS'(1) << (FRAC_BITS - 1));
      scaled  = total[TOTAL_BITS-1:FRAC_BITS];

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in   = pop_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            part_a_in = ACC_BITS'(cmd_ff.sample * cmd_ff.weight_a);
            part_b_in = ACC_BITS'(cmd_ff.sample * cmd_ff.weight_b);
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            if (cmd_ff.emit) begin
               sum_in   = acc_sum;
               acc_in   = part_b_ff;
               state_in = ST_SCALE;
            end else begin
               acc_in   = acc_sum;
               state_in = ST_IDLE;
            end
         end
         ST_SCALE: begin
            prod_in  = sum_ff * recip[RECIP_BITS-2:0];
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_value_in = (scaled > VAL_BITS'({SAMPLE_BITS{1'b1}}))
                            ? {SAMPLE_BITS{1'b1}} : scaled[SAMPLE_BITS-1:0];
               out_index_in = cmd_ff.out_index;
               last_in      = cmd_ff.last;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      part_a_ff    <= part_a_in;
      part_b_ff    <= part_b_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      out_value_ff <= out_value_in;
      out_index_ff <= out_index_in;
      last_ff      <= last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_value = out_value_ff;
   assign rsp_chan.out_index = out_index_ff;
   assign rsp_chan.last      = last_ff;
endmodule
`default_nettype wire

// ===== rtl/aad_checker.sv =====
// Port-level checks of the area-average downsampler, bound to the top level.
`default_nettype none
module aad_checker
   import aad_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic [SAMPLE_BITS-1:0]  rsp_out_value,
   input  wire logic [POS_BITS-1:0]     rsp_out_index,
   input  wire logic                    rsp_last
);
   logic [POS_BITS-1:0] exp_index_ff, exp_index_in;
   logic                rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   // expected index of the next result in the column
   always_comb begin
      exp_index_in = exp_index_ff;
      if (csr_we && (csr_index == CSR_IN_LEN || csr_index == CSR_OUT_LEN)) begin
         exp_index_in = '0;
      end else if (rsp_fire) begin
         exp_index_in = rsp_last ? '0 : exp_index_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_index_ff <= '0;
      end else begin
         exp_index_ff <= exp_index_in;
      end
   end

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   a_index_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> rsp_out_index == exp_index_ff)
      else $error("result index out of sequence");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_out_value) && $stable(rsp_out_index) && $stable(rsp_last))
      else $error("result payload changed while stalled");
endmodule

bind area_average_downsampler aad_checker u_aad_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_we        (csr_we),
   .csr_index     (csr_index),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_value (rsp_chan.out_value),
   .rsp_out_index (rsp_chan.out_index),
   .rsp_last      (rsp_chan.last)
);
`default_nettype wire
